### hw/rtl/assert_macros.svh
// Assertion helpers used by qcmr_vertex.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock, masked while reset is asserted
`define QCMR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every clock, reset included
`define QCMR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### hw/rtl/qcmr_pkg.sv
package qcmr_pkg;

	// Divider: 32 quotient bits, two restoring steps per stage
	localparam int DIV_BITS   = 32;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

	localparam int NUM_ENTRIES = 9;

	// Apex vertex number, final one of each run
	localparam logic [2:0] CORNER_APEX = 3'd4;

	// 0.5 in Q16.16
	localparam logic [33:0] HALF_Q16 = 34'd32768;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [8:0]       neg;
		logic             degen;
	} meta_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] low;
	} divst_t;

	// One restoring step: quotient bit shifts into the low word
	function automatic divst_t div_step(input divst_t s, input logic [32:0] den);
		logic [33:0] t;
		logic        ge;
		divst_t      r;
		t     = {s.rem, s.low[31]};
		ge    = (t >= {1'b0, den});
		r.rem = ge ? 33'(t - {1'b0, den}) : t[32:0];
		r.low = {s.low[30:0], ge};
		return r;
	endfunction

	// Marker corner offsets, element 0 is x
	function automatic logic [2:0][33:0] corner_offset(input logic [2:0] c);
		logic [33:0]      p;
		logic [33:0]      m;
		logic [2:0][33:0] r;
		p = HALF_Q16;
		m = 34'(-HALF_Q16);
		unique case (c)
			3'd0:        r = {p, m, m};
			3'd1:        r = {p, p, m};
			3'd2:        r = {p, p, p};
			3'd3:        r = {p, m, p};
			CORNER_APEX: r = {m, 34'd0, 34'd0};
			default:     r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/qcmr_div.sv
module qcmr_div (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] den,
	input  logic [31:0] rem,
	input  logic [31:0] low,
	output logic [30:0] quot
);
	import qcmr_pkg::*;

	divst_t      st_s  [DIV_STAGES];
	logic [32:0] den_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		divst_t      src;
		divst_t      mid;
		logic [32:0] dsrc;

		if (g == 0) begin : g_first
			assign src  = '{rem: {1'b0, rem}, low: low};
			assign dsrc = den;
		end else begin : g_next
			assign src  = st_s[g-1];
			assign dsrc = den_s[g-1];
		end

		// Run this stage's restoring steps
		always_comb begin
			mid = src;
			for (int i = 0; i < DIV_STEPS; i++) begin
				mid = div_step(mid, dsrc);
			end
		end

		// Advance with the front pipeline
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g]  <= mid;
				den_s[g] <= dsrc;
			end
		end
	end

	assign quot = st_s[DIV_STAGES-1].low[30:0];

endmodule

### hw/rtl/qcmr_vertex.sv
`include "assert_macros.svh"

module qcmr_vertex (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [8:0][30:0]      quot,
	input  qcmr_pkg::meta_t       meta,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_corner,
	output logic [2:0][31:0]      out_vert,
	output logic                  out_last,
	output logic                  out_degen
);
	import qcmr_pkg::*;

	logic be, em_load, emit;

	logic             em_valid_q;
	logic [2:0]       cnt_q;
	logic [8:0][31:0] m_q;
	logic [2:0][31:0] pos_q;
	logic             degen_q;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2:0]       corner_s1, corner_s2, corner_s3, corner_s4;
	logic             degen_s1, degen_s2, degen_s3, degen_s4;
	logic [8:0][31:0] m_s1;
	logic [2:0][33:0] v_s1;
	logic [8:0][49:0] pl_s2, ph_s2;
	logic [8:0][65:0] prod_s3;
	logic [2:0][67:0] acc_s4;

	logic             out_valid_q;
	logic [2:0]       out_corner_q;
	logic [2:0][31:0] out_vert_q;
	logic             out_degen_q;

	logic [2:0][33:0] offs;
	logic [2:0][31:0] sat_c;

	assign be       = !out_valid_q || out_ready;
	assign emit     = em_valid_q && be;
	assign em_load  = !em_valid_q || ((cnt_q == CORNER_APEX) && be);
	assign in_ready = em_load;
	assign offs     = corner_offset(cnt_q);

	// Hold one matrix and count out its five vertices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			cnt_q      <= '0;
		end else if (em_load) begin
			em_valid_q <= in_valid;
			cnt_q      <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// Apply the sign of each matrix entry on load
	always_ff @(posedge clk) begin
		if (em_load) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				m_q[i] <= meta.neg[i] ? 32'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
			end
			pos_q   <= meta.pos;
			degen_q <= meta.degen;
		end
	end

	// Valid bits of the vertex pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (be) begin
			valid_s1    <= emit;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Offset vertex, partial products, full products, row sums and the registered output
	always_ff @(posedge clk) begin
		if (be) begin
			for (int k = 0; k < 3; k++) begin
				v_s1[k] <= 34'($signed(pos_q[k])) + offs[k];
			end
			m_s1      <= m_q;
			corner_s1 <= cnt_q;
			degen_s1  <= degen_q;

			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					pl_s2[k*3+j] <= 50'($signed({1'b0, v_s1[k][16:0]})
						* $signed(m_s1[k*3+j]));
					ph_s2[k*3+j] <= 50'($signed(v_s1[k][33:17]) * $signed(m_s1[k*3+j]));
				end
			end
			corner_s2 <= corner_s1;
			degen_s2  <= degen_s1;

			for (int i = 0; i < NUM_ENTRIES; i++) begin
				prod_s3[i] <= (66'($signed(ph_s2[i])) <<< 17) + 66'($signed(pl_s2[i]));
			end
			corner_s3 <= corner_s2;
			degen_s3  <= degen_s2;

			for (int j = 0; j < 3; j++) begin
				acc_s4[j] <= 68'($signed(prod_s3[j])) + 68'($signed(prod_s3[3+j]))
					+ 68'($signed(prod_s3[6+j])) + 68'sd536870912;
			end
			corner_s4 <= corner_s3;
			degen_s4  <= degen_s3;

			out_vert_q   <= sat_c;
			out_corner_q <= corner_s4;
			out_degen_q  <= degen_s4;
		end
	end

	// Drop the fraction and clamp to the 32-bit range; a degenerate matrix gives zero
	always_comb begin
		logic signed [37:0] sh;
		for (int j = 0; j < 3; j++) begin
			sh = 38'($signed(acc_s4[j]) >>> 30);
			if (degen_s4) begin
				sat_c[j] = '0;
			end else if (sh > 38'sd2147483647) begin
				sat_c[j] = 32'h7fff_ffff;
			end else if (sh < -38'sd2147483648) begin
				sat_c[j] = 32'h8000_0000;
			end else begin
				sat_c[j] = sh[31:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_corner = out_corner_q;
	assign out_vert   = out_vert_q;
	assign out_last   = (out_corner_q == CORNER_APEX);
	assign out_degen  = out_degen_q;

	`QCMR_ASSERT(a_cnt_range, em_valid_q |-> (cnt_q <= CORNER_APEX), "vertex count out of range")
	`QCMR_ASSERT(a_last_reload, (emit && (cnt_q == CORNER_APEX)) |-> em_load, "no reload after apex")
	`QCMR_ASSERT_ALWAYS(a_degen_zero, (out_valid_q && out_degen_q) |-> (out_vert_q == '0), "degenerate vertex not zero")

endmodule

### hw/rtl/quaternion_camera_marker_rotate_core.sv
// Front end: three arithmetic stages and a 16-stage restoring divider bank, holding while
// the vertex sequencer cannot take a matrix. The sequencer sends five vertices, one per
// cycle while the output is not stalled, and loads the next matrix as it sends the apex.
// Reset: arst_n clears all valid bits and the vertex counter; data registers are not reset.
module quaternion_camera_marker_rotate_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // vert_x, vert_y, vert_z
	output logic         m_axis_tlast,
	output logic [3:0]   m_axis_tuser   // corner, degenerate
);
	import qcmr_pkg::*;

	logic fe, em_ready;

	logic signed [15:0] qx, qy, qz, qw;

	logic              valid_s1, valid_s2, valid_s3;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic [2:0][31:0]  pos_s1, pos_s2;
	logic signed [33:0] n_s2;
	logic [8:0][33:0]  num_s2;
	logic [8:0][31:0]  rem_s3, low_s3;
	logic [32:0]       den_s3;
	meta_t             meta_s3;

	logic [8:0]        neg_c;
	logic [8:0][63:0]  x_c;
	logic [32:0]       mag;

	logic              vd_s [DIV_STAGES];
	meta_t             md_s [DIV_STAGES];
	logic [8:0][30:0]  quot;

	logic [2:0][31:0]  vert;
	logic [2:0]        corner;
	logic              degen;

	assign qx = s_axis_tdata[15:0];
	assign qy = s_axis_tdata[31:16];
	assign qz = s_axis_tdata[47:32];
	assign qw = s_axis_tdata[63:48];

	assign fe            = !vd_s[DIV_STAGES-1] || em_ready;
	assign s_axis_tready = fe;

	// Front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (fe) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Quaternion products, then norm and matrix numerators, then divider inputs
	always_ff @(posedge clk) begin
		if (fe) begin
			xx_s1  <= 32'(qx * qx);
			yy_s1  <= 32'(qy * qy);
			zz_s1  <= 32'(qz * qz);
			ww_s1  <= 32'(qw * qw);
			xy_s1  <= 32'(qx * qy);
			xz_s1  <= 32'(qx * qz);
			yz_s1  <= 32'(qy * qz);
			wx_s1  <= 32'(qw * qx);
			wy_s1  <= 32'(qw * qy);
			wz_s1  <= 32'(qw * qz);
			pos_s1 <= s_axis_tdata[159:64];

			n_s2 <= 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1) + 34'(ww_s1);
			num_s2[0] <= 34'(xx_s1) + 34'(ww_s1) - 34'(yy_s1) - 34'(zz_s1);
			num_s2[1] <= 34'((34'(xy_s1) + 34'(wz_s1)) <<< 1);
			num_s2[2] <= 34'((34'(xz_s1) - 34'(wy_s1)) <<< 1);
			num_s2[3] <= 34'((34'(xy_s1) - 34'(wz_s1)) <<< 1);
			num_s2[4] <= 34'(yy_s1) + 34'(ww_s1) - 34'(xx_s1) - 34'(zz_s1);
			num_s2[5] <= 34'((34'(yz_s1) + 34'(wx_s1)) <<< 1);
			num_s2[6] <= 34'((34'(xz_s1) + 34'(wy_s1)) <<< 1);
			num_s2[7] <= 34'((34'(yz_s1) - 34'(wx_s1)) <<< 1);
			num_s2[8] <= 34'(zz_s1) + 34'(ww_s1) - 34'(xx_s1) - 34'(yy_s1);
			pos_s2    <= pos_s1;

			for (int i = 0; i < NUM_ENTRIES; i++) begin
				rem_s3[i] <= x_c[i][63:32];
				low_s3[i] <= x_c[i][31:0];
			end
			den_s3        <= n_s2[32:0];
			meta_s3.pos   <= pos_s2;
			meta_s3.neg   <= neg_c;
			meta_s3.degen <= (n_s2 == '0);
		end
	end

	// Dividend for round-half-away: |num| * 2^30 + n/2
	always_comb begin
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			neg_c[i] = num_s2[i][33];
			mag      = neg_c[i] ? 33'(-$signed(num_s2[i])) : num_s2[i][32:0];
			x_c[i]   = {1'b0, mag, 30'b0} + 64'(n_s2[32:1]);
		end
	end

	// Carry valid and side data alongside the dividers
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_line
		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vd_s[g] <= 1'b0;
				end else if (fe) begin
					vd_s[g] <= valid_s3;
				end
			end
			always_ff @(posedge clk) begin
				if (fe) begin
					md_s[g] <= meta_s3;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vd_s[g] <= 1'b0;
				end else if (fe) begin
					vd_s[g] <= vd_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				if (fe) begin
					md_s[g] <= md_s[g-1];
				end
			end
		end
	end

	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_div
		qcmr_div u_div (
			.clk  (clk),
			.en   (fe),
			.den  (den_s3),
			.rem  (rem_s3[i]),
			.low  (low_s3[i]),
			.quot (quot[i])
		);
	end

	qcmr_vertex u_vertex (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (vd_s[DIV_STAGES-1]),
		.in_ready   (em_ready),
		.quot       (quot),
		.meta       (md_s[DIV_STAGES-1]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_corner (corner),
		.out_vert   (vert),
		.out_last   (m_axis_tlast),
		.out_degen  (degen)
	);

	assign m_axis_tdata = vert;
	assign m_axis_tuser = {degen, corner};

endmodule
